### rtl/core/cllm_pkg.sv
// Package for the circular linked list manager core.
// Holds shared codes, state and command types for the controller and datapath.
// No dependencies.
`default_nettype none

package cllm_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int MAX_RESULTS      = 16;
    localparam int ACTION_W         = 3;
    localparam int STATUS_W         = 2;
    localparam int COUNT_OUT_W      = 5;
    localparam int DATA_W           = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_AFTER = 3'd1,
        ACT_DEL_AFTER = 3'd2,
        ACT_INS_END   = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_READOUT   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LINK_A,
        ST_LINK_B,
        ST_FRONT,
        ST_SEARCH,
        ST_UNLINK,
        ST_EMIT_DONE,
        ST_READ
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_INIT_ONE,
        OP_SET_T_TAIL,
        OP_FRONT,
        OP_ADVANCE,
        OP_LINK_A,
        OP_LINK_B,
        OP_UNLINK,
        OP_MAKE_EMPTY,
        OP_EMIT_STATUS,
        OP_EMIT_ITEM
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                empty;
        logic                full;
        logic                single;
        logic                match;
        logic                walk_last;
        logic                read_last;
        logic                out_busy;
    } dp_flags_t;

endpackage

`default_nettype wire

### rtl/core/cllm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cllm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/cllm_ctrl.sv
// Controller state machine of the circular linked list manager.
// Depends on cllm_pkg; drives commands into cllm_datapath.
`default_nettype none

module cllm_ctrl
    import cllm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire dp_flags_t flags,
    output dp_cmd_t        cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.code   = STAT_DONE;
        in_ready   = (state_reg == ST_IDLE) && !flags.out_busy;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (flags.action) inside
                    ACT_INS_FRONT, ACT_INS_END:
                    begin
                        if (flags.full)
                        begin
                            cmd.op     = OP_EMIT_STATUS;
                            cmd.code   = STAT_FULL;
                            state_next = ST_IDLE;
                        end
                        else if (flags.empty)
                        begin
                            cmd.op     = OP_INIT_ONE;
                            state_next = ST_EMIT_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_SET_T_TAIL;
                            state_next = ST_LINK_A;
                        end
                    end
                    ACT_INS_AFTER, ACT_DEL_AFTER:
                    begin
                        if (flags.empty)
                        begin
                            cmd.op     = OP_EMIT_STATUS;
                            cmd.code   = STAT_EMPTY;
                            state_next = ST_IDLE;
                        end
                        else if (flags.full && flags.action == ACT_INS_AFTER)
                        begin
                            cmd.op     = OP_EMIT_STATUS;
                            cmd.code   = STAT_FULL;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_SET_T_TAIL;
                            state_next = ST_FRONT;
                        end
                    end
                    ACT_DEL_END:
                    begin
                        if (flags.empty)
                        begin
                            cmd.op     = OP_EMIT_STATUS;
                            cmd.code   = STAT_EMPTY;
                            state_next = ST_IDLE;
                        end
                        else if (flags.single)
                        begin
                            cmd.op     = OP_MAKE_EMPTY;
                            state_next = ST_EMIT_DONE;
                        end
                        else
                        begin
                            cmd.op     = OP_SET_T_TAIL;
                            state_next = ST_UNLINK;
                        end
                    end
                    ACT_READOUT:
                    begin
                        if (flags.empty)
                        begin
                            cmd.op     = OP_EMIT_STATUS;
                            cmd.code   = STAT_EMPTY;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_SET_T_TAIL;
                            state_next = ST_FRONT;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_EMIT_STATUS;
                        cmd.code   = STAT_DONE;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FRONT:
            begin
                cmd.op = OP_FRONT;
                if (flags.action == ACT_READOUT)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (flags.match)
                begin
                    if (flags.action == ACT_INS_AFTER)
                    begin
                        cmd.op     = OP_LINK_A;
                        state_next = ST_LINK_B;
                    end
                    else if (flags.single)
                    begin
                        cmd.op     = OP_MAKE_EMPTY;
                        state_next = ST_EMIT_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_ADVANCE;
                        state_next = ST_UNLINK;
                    end
                end
                else if (flags.walk_last)
                begin
                    cmd.op     = OP_EMIT_STATUS;
                    cmd.code   = STAT_NOT_FOUND;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op = OP_ADVANCE;
                end
            end
            ST_LINK_A:
            begin
                cmd.op     = OP_LINK_A;
                state_next = ST_LINK_B;
            end
            ST_LINK_B:
            begin
                cmd.op     = OP_LINK_B;
                state_next = ST_EMIT_DONE;
            end
            ST_UNLINK:
            begin
                cmd.op     = OP_UNLINK;
                state_next = ST_EMIT_DONE;
            end
            ST_EMIT_DONE:
            begin
                if (!flags.out_busy)
                begin
                    cmd.op     = OP_EMIT_STATUS;
                    cmd.code   = STAT_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (!flags.out_busy)
                begin
                    cmd.op = OP_EMIT_ITEM;
                    if (flags.read_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/cllm_datapath.sv
// Datapath of the circular linked list manager: node pool RAMs, list registers
// and the output register. Depends on cllm_pkg and cllm_ram.
`default_nettype none

module cllm_datapath
    import cllm_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dp_cmd_t             cmd,
    output dp_flags_t                flags,
    input  wire logic [ACTION_W-1:0] in_action,
    input  wire logic [DATA_W-1:0]   in_key,
    input  wire logic [DATA_W-1:0]   in_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      out_status,
    output logic [DATA_W-1:0]        out_item_value,
    output logic [COUNT_OUT_W-1:0]   out_node_count,
    output logic                     out_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ACTION_W-1:0]    act_reg, act_next;
    logic [DATA_W-1:0]      key_reg, key_next;
    logic [DATA_W-1:0]      val_reg, val_next;
    logic [AW-1:0]          t_reg, t_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [AW-1:0]          n_reg, n_next;
    logic [AW-1:0]          q_reg, q_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic                   nonempty_reg, nonempty_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CAPACITY-1:0]    used_reg, used_next;
    logic                   ov_reg, ov_next;
    logic [STATUS_W-1:0]    ostat_reg, ostat_next;
    logic [DATA_W-1:0]      oval_reg, oval_next;
    logic [COUNT_OUT_W-1:0] ocnt_reg, ocnt_next;
    logic                   olast_reg, olast_next;

    logic              vr_we, nr_we, pr_we;
    logic [AW-1:0]     vr_waddr, nr_waddr, pr_waddr;
    logic [DATA_W-1:0] vr_wdata, vr_rdata;
    logic [AW-1:0]     nr_wdata, nr_rdata, pr_wdata, pr_rdata;

    logic [AW-1:0] free_slot;
    logic [31:0]   cnt32, lim32, inc32;

    cllm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_val_ram (
        .clk   (clk),
        .we    (vr_we),
        .waddr (vr_waddr),
        .wdata (vr_wdata),
        .raddr (t_next),
        .rdata (vr_rdata)
    );

    cllm_ram #(.WIDTH(AW), .DEPTH(CAPACITY), .ADDR_W(AW)) u_next_ram (
        .clk   (clk),
        .we    (nr_we),
        .waddr (nr_waddr),
        .wdata (nr_wdata),
        .raddr (t_next),
        .rdata (nr_rdata)
    );

    cllm_ram #(.WIDTH(AW), .DEPTH(CAPACITY), .ADDR_W(AW)) u_prev_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (t_next),
        .rdata (pr_rdata)
    );

    always_comb
    begin
        free_slot = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (!used_reg[k])
            begin
                free_slot = AW'(k);
            end
        end
    end

    always_comb
    begin
        cnt32 = 32'(count_reg);
        lim32 = (cnt32 < 32'(MAX_RESULTS)) ? cnt32 : 32'(MAX_RESULTS);
        inc32 = 32'(i_reg) + 32'd1;
    end

    always_comb
    begin
        flags.action    = act_reg;
        flags.empty     = !nonempty_reg;
        flags.full      = count_reg >= CW'(CAPACITY);
        flags.single    = count_reg == CW'(1);
        flags.match     = vr_rdata == key_reg;
        flags.walk_last = inc32 == cnt32;
        flags.read_last = inc32 == lim32;
        flags.out_busy  = ov_reg;
    end

    always_comb
    begin
        act_next      = act_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        t_next        = t_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        q_next        = q_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        count_next    = count_reg;
        used_next     = used_reg;
        ov_next       = ov_reg && !out_ready;
        ostat_next    = ostat_reg;
        oval_next     = oval_reg;
        ocnt_next     = ocnt_reg;
        olast_next    = olast_reg;
        vr_we         = 1'b0;
        nr_we         = 1'b0;
        pr_we         = 1'b0;
        vr_waddr      = free_slot;
        nr_waddr      = free_slot;
        pr_waddr      = free_slot;
        vr_wdata      = val_reg;
        nr_wdata      = free_slot;
        pr_wdata      = free_slot;
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                act_next = in_action;
                key_next = in_key;
                val_next = in_value;
            end
            OP_INIT_ONE:
            begin
                vr_we                = 1'b1;
                nr_we                = 1'b1;
                pr_we                = 1'b1;
                tail_next            = free_slot;
                nonempty_next        = 1'b1;
                used_next[free_slot] = 1'b1;
                count_next           = count_reg + CW'(1);
            end
            OP_SET_T_TAIL:
            begin
                t_next = tail_reg;
                i_next = '0;
            end
            OP_FRONT:
            begin
                t_next = nr_rdata;
                i_next = '0;
            end
            OP_ADVANCE:
            begin
                t_next = nr_rdata;
                i_next = i_reg + CW'(1);
            end
            OP_LINK_A:
            begin
                n_next               = free_slot;
                q_next               = nr_rdata;
                vr_we                = 1'b1;
                nr_we                = 1'b1;
                nr_wdata             = nr_rdata;
                pr_we                = 1'b1;
                pr_wdata             = t_reg;
                used_next[free_slot] = 1'b1;
                count_next           = count_reg + CW'(1);
            end
            OP_LINK_B:
            begin
                pr_we    = 1'b1;
                pr_waddr = q_reg;
                pr_wdata = n_reg;
                nr_we    = 1'b1;
                nr_waddr = t_reg;
                nr_wdata = n_reg;
                if (act_reg == ACT_INS_END
                    || (act_reg == ACT_INS_AFTER && t_reg == tail_reg))
                begin
                    tail_next = n_reg;
                end
            end
            OP_UNLINK:
            begin
                nr_we            = 1'b1;
                nr_waddr         = pr_rdata;
                nr_wdata         = nr_rdata;
                pr_we            = 1'b1;
                pr_waddr         = nr_rdata;
                pr_wdata         = pr_rdata;
                used_next[t_reg] = 1'b0;
                count_next       = count_reg - CW'(1);
                if (t_reg == tail_reg)
                begin
                    tail_next = pr_rdata;
                end
            end
            OP_MAKE_EMPTY:
            begin
                used_next[tail_reg] = 1'b0;
                count_next          = '0;
                nonempty_next       = 1'b0;
                tail_next           = '0;
            end
            OP_EMIT_STATUS:
            begin
                ov_next    = 1'b1;
                ostat_next = cmd.code;
                oval_next  = '0;
                ocnt_next  = cnt32[COUNT_OUT_W-1:0];
                olast_next = 1'b1;
            end
            OP_EMIT_ITEM:
            begin
                ov_next    = 1'b1;
                ostat_next = STAT_DONE;
                oval_next  = vr_rdata;
                ocnt_next  = cnt32[COUNT_OUT_W-1:0];
                olast_next = flags.read_last;
                t_next     = nr_rdata;
                i_next     = i_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg     <= '0;
            nonempty_reg <= 1'b0;
            count_reg    <= '0;
            used_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            count_reg    <= count_next;
            used_reg     <= used_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        t_reg     <= t_next;
        i_reg     <= i_next;
        n_reg     <= n_next;
        q_reg     <= q_next;
        ostat_reg <= ostat_next;
        oval_reg  <= oval_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    assign out_valid      = ov_reg;
    assign out_status     = ostat_reg;
    assign out_item_value = oval_reg;
    assign out_node_count = ocnt_reg;
    assign out_last       = olast_reg;

endmodule

`default_nettype wire

### rtl/core/circular_linked_list_manager_core.sv
// Top level of the circular linked list manager core.
// Depends on cllm_pkg, cllm_ctrl, cllm_datapath and cllm_ram.
//
// The slave channel takes one action per transaction: s_tuser carries the
// action code and s_tdata carries key and value. The master channel returns
// results; m_tuser carries the status, m_tdata the item value and node count,
// and m_tlast marks the final result of each action.
// One action is worked on at a time.
// A key search walks the list one node per cycle through the node RAMs for
// insert after key and delete after key.
// A readout gives up to 16 results, one at a time as the output register frees.
// The next action is taken once the last result has left the output register.
// When the receiver stalls, the result holds in the output register and the
// walk waits. Reset empties the list at once; node storage is not cleared.
`default_nettype none

module circular_linked_list_manager_core
    import cllm_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // key [31:0], value [63:32]
    input  wire logic [2:0]  s_tuser,  // action [2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // item_value [31:0], node_count [36:32], zero
    output logic [1:0]       m_tuser,  // status [1:0]
    output logic             m_tlast   // last_of_run
);

    dp_cmd_t                cmd;
    dp_flags_t              flags;
    logic [DATA_W-1:0]      item_value;
    logic [COUNT_OUT_W-1:0] node_count;

    cllm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    cllm_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .flags          (flags),
        .in_action      (s_tuser),
        .in_key         (s_tdata[31:0]),
        .in_value       (s_tdata[63:32]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_status     (m_tuser),
        .out_item_value (item_value),
        .out_node_count (node_count),
        .out_last       (m_tlast)
    );

    assign m_tdata = {3'b000, node_count, item_value};

endmodule

`default_nettype wire
